@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

// Implication checked on the edge after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

@@ sv/awt_pkg.sv @@
package awt_pkg;

	localparam int WATCH_ENTRIES = 16;
	localparam int RANK_W = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;
	localparam int CUR_W = $clog2(WATCH_ENTRIES + 1);
	localparam int IDX_W = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;

	typedef enum logic [1:0] {
		KIND_SET   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_POLL  = 2'd2,
		KIND_WORD  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		COND_GT = 2'd0,
		COND_LT = 2'd1,
		COND_EQ = 2'd2,
		COND_NE = 2'd3
	} cond_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_ZERO_ADDR  = 3'd1,
		ST_FULL       = 3'd2,
		ST_READ       = 3'd3,
		ST_EVENT      = 3'd4,
		ST_NO_EVENT   = 3'd5,
		ST_UNEXPECTED = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_LOOKUP = 2'd1,
		S_EXEC   = 2'd2,
		S_RESULT = 2'd3
	} state_t;

	typedef struct packed {
		kind_t       kind;
		cond_t       condition;
		logic [63:0] watch_address;
		logic [63:0] compare_word;
		logic [63:0] event_label;
		logic [63:0] memory_word;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] request_address;
		logic [63:0] fired_label;
	} out_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic exec;
	} cmd_t;

endpackage

@@ sv/address_watch_table.sv @@
// Address watch table.
// Request channel: cmd_valid / cmd_stall carry one cmd item (set, clear,
// start poll or returned memory word). Response channel: rsp_valid /
// rsp_stall carry one rsp item for every request.
// A request is taken only when the block is idle; it then runs a parallel
// match over all entries (lookup state), then applies the update and forms
// the response (exec state); the response is registered and held valid
// (result state) until the receiver takes it. No new request is taken
// until the response of the last one has been taken.
// A poll answers read request with an address; the reader returns the word
// as a memory word request, and the poll walks entries newest first until a
// condition holds (event) or the entries run out (no event).
// Reset empties the table and ends any poll; entry contents are left as is.
// While a response waits on rsp_stall, it is held and cmd_stall stays high.
module address_watch_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  awt_pkg::in_t  cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output awt_pkg::out_t rsp
);

	awt_pkg::cmd_t ctl;

	awt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	awt_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.rsp    (rsp)
	);

endmodule

@@ sv/awt_ctrl.sv @@
module awt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output awt_pkg::cmd_t ctl
);

	awt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= awt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl        = '0;
		cmd_stall  = 1'b1;
		rsp_valid  = 1'b0;
		unique case (state_q)
			awt_pkg::S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = awt_pkg::S_LOOKUP;
				end
			end
			awt_pkg::S_LOOKUP: begin
				ctl.lookup = 1'b1;
				state_d    = awt_pkg::S_EXEC;
			end
			awt_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = awt_pkg::S_RESULT;
			end
			awt_pkg::S_RESULT: begin
				rsp_valid = 1'b1;
				if (!rsp_stall) begin
					state_d = awt_pkg::S_IDLE;
				end
			end
			default: state_d = awt_pkg::S_IDLE;
		endcase
	end

endmodule

@@ sv/awt_datapath.sv @@
module awt_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  awt_pkg::cmd_t ctl,
	input  awt_pkg::in_t  cmd,
	output awt_pkg::out_t rsp
);

	localparam int N = awt_pkg::WATCH_ENTRIES;

	awt_pkg::in_t item_q;
	awt_pkg::out_t rsp_q;
	awt_pkg::out_t rsp_d;

	logic [N-1:0]               valid_q;
	awt_pkg::cond_t             cond_q [N];
	logic [63:0]                addr_q [N];
	logic [63:0]                cmp_q  [N];
	logic [63:0]                label_q[N];
	logic [awt_pkg::RANK_W-1:0] rank_q [N];

	logic                       active_q;
	logic [awt_pkg::CUR_W-1:0]  cursor_q;

	logic [N-1:0]               hit_vec_q, r0_vec_q, cur_vec_q, nxt_vec_q;
	logic [awt_pkg::IDX_W-1:0]  free_idx_q;
	logic                       full_q;

	logic [N-1:0]               hit_vec_d, r0_vec_d, cur_vec_d, nxt_vec_d;
	logic [awt_pkg::IDX_W-1:0]  free_idx_d;
	logic                       full_d;
	logic [awt_pkg::CUR_W-1:0]  cur_next;

	logic [awt_pkg::RANK_W-1:0] hit_rank;
	logic [63:0]                r0_addr, nxt_addr, cur_cmp, cur_label;
	logic [1:0]                 cur_cond;
	logic                       holds, zero_addr;

	assign cur_next = cursor_q + 1'b1;

	always_comb begin
		full_d     = 1'b1;
		free_idx_d = '0;
		for (int i = 0; i < N; i++) begin
			hit_vec_d[i] = valid_q[i] && (addr_q[i] == item_q.watch_address);
			r0_vec_d[i]  = valid_q[i] && (rank_q[i] == '0);
			cur_vec_d[i] = valid_q[i] &&
				({{(awt_pkg::CUR_W - awt_pkg::RANK_W){1'b0}}, rank_q[i]} == cursor_q);
			nxt_vec_d[i] = valid_q[i] &&
				({{(awt_pkg::CUR_W - awt_pkg::RANK_W){1'b0}}, rank_q[i]} == cur_next);
		end
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				full_d     = 1'b0;
				free_idx_d = awt_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		hit_rank  = '0;
		r0_addr   = '0;
		nxt_addr  = '0;
		cur_cmp   = '0;
		cur_label = '0;
		cur_cond  = '0;
		for (int i = 0; i < N; i++) begin
			hit_rank  = hit_rank  | (hit_vec_q[i] ? rank_q[i] : '0);
			r0_addr   = r0_addr   | (r0_vec_q[i]  ? addr_q[i] : '0);
			nxt_addr  = nxt_addr  | (nxt_vec_q[i] ? addr_q[i] : '0);
			cur_cmp   = cur_cmp   | (cur_vec_q[i] ? cmp_q[i] : '0);
			cur_label = cur_label | (cur_vec_q[i] ? label_q[i] : '0);
			cur_cond  = cur_cond  | (cur_vec_q[i] ? 2'(cond_q[i]) : 2'b00);
		end
		unique case (awt_pkg::cond_t'(cur_cond))
			awt_pkg::COND_GT: holds = item_q.memory_word > cur_cmp;
			awt_pkg::COND_LT: holds = item_q.memory_word < cur_cmp;
			awt_pkg::COND_EQ: holds = item_q.memory_word == cur_cmp;
			default:          holds = item_q.memory_word != cur_cmp;
		endcase
		zero_addr = (item_q.watch_address == '0);
	end

	always_comb begin
		rsp_d = '{status: awt_pkg::ST_OK, request_address: '0, fired_label: '0};
		if (ctl.exec) begin
			unique case (item_q.kind)
				awt_pkg::KIND_SET: begin
					if (zero_addr) begin
						rsp_d.status = awt_pkg::ST_ZERO_ADDR;
					end else if (!(|hit_vec_q) && full_q) begin
						rsp_d.status = awt_pkg::ST_FULL;
					end
				end
				awt_pkg::KIND_CLEAR: begin
					rsp_d.status = awt_pkg::ST_OK;
				end
				awt_pkg::KIND_POLL: begin
					if (|r0_vec_q) begin
						rsp_d.status          = awt_pkg::ST_READ;
						rsp_d.request_address = r0_addr;
					end else begin
						rsp_d.status = awt_pkg::ST_NO_EVENT;
					end
				end
				default: begin
					if (!active_q) begin
						rsp_d.status = awt_pkg::ST_UNEXPECTED;
					end else if ((|cur_vec_q) && holds) begin
						rsp_d.status      = awt_pkg::ST_EVENT;
						rsp_d.fired_label = cur_label;
					end else if ((|cur_vec_q) && (|nxt_vec_q)) begin
						rsp_d.status          = awt_pkg::ST_READ;
						rsp_d.request_address = nxt_addr;
					end else begin
						rsp_d.status = awt_pkg::ST_NO_EVENT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q <= cmd;
		end
		if (ctl.lookup) begin
			hit_vec_q  <= hit_vec_d;
			r0_vec_q   <= r0_vec_d;
			cur_vec_q  <= cur_vec_d;
			nxt_vec_q  <= nxt_vec_d;
			free_idx_q <= free_idx_d;
			full_q     <= full_d;
		end
		if (ctl.exec) begin
			rsp_q <= rsp_d;
			unique case (item_q.kind)
				awt_pkg::KIND_SET: begin
					if (zero_addr) begin
					end else if (|hit_vec_q) begin
						for (int i = 0; i < N; i++) begin
							if (hit_vec_q[i]) begin
								cond_q[i]  <= item_q.condition;
								cmp_q[i]   <= item_q.compare_word;
								label_q[i] <= item_q.event_label;
							end
						end
					end else if (!full_q) begin
						for (int i = 0; i < N; i++) begin
							if (awt_pkg::IDX_W'(i) == free_idx_q) begin
								rank_q[i] <= '0;
							end else if (valid_q[i]) begin
								rank_q[i] <= rank_q[i] + 1'b1;
							end
						end
						cond_q[free_idx_q]  <= item_q.condition;
						addr_q[free_idx_q]  <= item_q.watch_address;
						cmp_q[free_idx_q]   <= item_q.compare_word;
						label_q[free_idx_q] <= item_q.event_label;
					end
				end
				awt_pkg::KIND_CLEAR: begin
					if (!zero_addr) begin
						for (int i = 0; i < N; i++) begin
							if (valid_q[i] && !hit_vec_q[i] && (|hit_vec_q) &&
								(rank_q[i] > hit_rank)) begin
								rank_q[i] <= rank_q[i] - 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			active_q <= 1'b0;
			cursor_q <= '0;
		end else if (ctl.exec) begin
			unique case (item_q.kind)
				awt_pkg::KIND_SET: begin
					active_q <= 1'b0;
					if (!zero_addr && !(|hit_vec_q) && !full_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
				awt_pkg::KIND_CLEAR: begin
					active_q <= 1'b0;
					if (zero_addr) begin
						valid_q <= '0;
					end else begin
						valid_q <= valid_q & ~hit_vec_q;
					end
				end
				awt_pkg::KIND_POLL: begin
					active_q <= |r0_vec_q;
					cursor_q <= '0;
				end
				default: begin
					if (active_q) begin
						if ((|cur_vec_q) && holds) begin
							active_q <= 1'b0;
						end else begin
							cursor_q <= cur_next;
							active_q <= (|cur_vec_q) && (|nxt_vec_q);
						end
					end
				end
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

@@ sv/awt_checker.sv @@
`include "assert_macros.svh"

module awt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input awt_pkg::out_t rsp
);

	`CHK_NEXT(a_busy_after_take, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)
	`CHK_IMPLY(a_rsp_latency, clk, arst_n, cmd_valid && !cmd_stall, ##3 rsp_valid)
	`CHK_IMPLY(a_no_take_pending, clk, arst_n, rsp_valid, cmd_stall)
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind address_watch_table awt_checker u_awt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
